// ----- hdl/sfsu_pkg.sv -----
// Package for the starfield star update block: sizes, register and code constants,
// and the payload and pipeline types.
// No dependencies; every module of the block refers to it by scoped names.
`default_nettype none
package sfsu_pkg;

    // Star table
    localparam int NUM_STARS = 128;
    localparam int IDX_W     = 7;
    localparam int POS_W     = 24;
    localparam int DEPTH_W   = 8;
    localparam int SPEED_W   = 2;

    // Projection arithmetic
    localparam int NUM_W     = 27;   // signed numerator x + centre * 256 * depth
    localparam int QUO_W     = 18;   // magnitude of numerator / 256
    localparam int SPAWN_MUL = 80;   // 20480 * 256 / 65536
    localparam logic signed [POS_W-1:0] SPAWN_BASE = -24'sd2621440;

    // Glyph thresholds
    localparam logic [DEPTH_W-1:0] FAR_DEPTH = 8'd60;
    localparam logic [DEPTH_W-1:0] MID_DEPTH = 8'd40;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_MODE   = 3'd6;

    // Color modes
    localparam logic [1:0] COLOR_NONE  = 2'd0;
    localparam logic [1:0] COLOR_EIGHT = 2'd1;
    localparam logic [1:0] COLOR_SIXTN = 2'd2;
    localparam logic [1:0] COLOR_GREY  = 2'd3;

    // Glyph classes
    localparam logic [2:0] GLYPH_FAR  = 3'd0;
    localparam logic [2:0] GLYPH_MID  = 3'd1;
    localparam logic [2:0] GLYPH_NEAR = 3'd2;
    localparam logic [2:0] GLYPH_WORD = 3'd3;
    localparam logic [2:0] GLYPH_TEXT = 3'd4;

    typedef struct packed {
        logic [IDX_W-1:0] star_index;
        logic [15:0]      spawn_x_a;
        logic [15:0]      spawn_y_a;
        logic             spawn_speed_a;
        logic [15:0]      spawn_x_b;
        logic [15:0]      spawn_y_b;
        logic             spawn_speed_b;
    } item_t;

    typedef struct packed {
        logic       visible;
        logic [9:0] column;
        logic [9:0] screen_row;
        logic [2:0] glyph_class;
        logic [1:0] word_index;
        logic [4:0] color_slot;
    } result_t;

    // One entry of the star table
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [DEPTH_W-1:0]      depth;
        logic [SPEED_W-1:0]      speed;
    } star_t;

    // What travels beside the dividers
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        star_t            star;
        logic [15:0]      spawn_x_b;
        logic [15:0]      spawn_y_b;
        logic             spawn_speed_b;
        logic             neg_x;
        logic             neg_y;
    } side_t;

endpackage
`default_nettype wire

// ----- hdl/starfield_star_update_top.sv -----
// Top level of the starfield star update block: star table, projection pipeline, registers.
// Depends on sfsu_pkg and sfsu_div.
`default_nettype none
// One star is taken per clock and its single result is on result with done high for
// one cycle once its item has passed the read register, stage 1, stage 2, the divider
// stages and the output register; the receiver cannot stall it. The star table sits
// in one memory that is read when an item is taken and written back when its result
// is registered, and the two 18-stage dividers project x and y. busy rises only while
// the offered star_index is still in flight, so visiting different stars gives one
// item per clock; a repeat visit of a star waits until its previous visit has been
// written back. The table needs no clearing pass: per-entry valid bits make every
// star start from zero after reset.
module starfield_star_update_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire sfsu_pkg::item_t                   item,
    output logic                                   done,
    output sfsu_pkg::result_t                      result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sfsu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sfsu_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int NS  = sfsu_pkg::NUM_STARS;
    localparam int IW  = sfsu_pkg::IDX_W;
    localparam int QW  = sfsu_pkg::QUO_W;
    localparam int NW  = sfsu_pkg::NUM_W;
    localparam int DW  = sfsu_pkg::DEPTH_W;

    // Configuration registers
    logic [9:0]  center_x_reg, center_y_reg;
    logic [10:0] cols_reg, rows_reg;
    logic [1:0]  color_mode_reg;
    logic        word_mode_reg, text_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= 10'd40;
            center_y_reg   <= 10'd12;
            cols_reg       <= 11'd80;
            rows_reg       <= 11'd24;
            color_mode_reg <= sfsu_pkg::COLOR_NONE;
            word_mode_reg  <= 1'b0;
            text_mode_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sfsu_pkg::REG_CENTER_X:    center_x_reg   <= cfg_data[9:0];
                sfsu_pkg::REG_CENTER_Y:    center_y_reg   <= cfg_data[9:0];
                sfsu_pkg::REG_SCREEN_COLS: cols_reg       <= cfg_data;
                sfsu_pkg::REG_SCREEN_ROWS: rows_reg       <= cfg_data;
                sfsu_pkg::REG_COLOR_MODE:  color_mode_reg <= cfg_data[1:0];
                sfsu_pkg::REG_WORD_MODE:   word_mode_reg  <= cfg_data[0];
                sfsu_pkg::REG_TEXT_MODE:   text_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline control and payload registers
    logic              rd_vld_reg, p1_vld_reg, p2_vld_reg;
    logic              dv_vld_reg [QW];
    sfsu_pkg::item_t   rd_item_reg;
    sfsu_pkg::star_t   rd_star_reg;
    logic              rd_hit_reg;
    sfsu_pkg::side_t   p1_reg, p2_reg;
    sfsu_pkg::side_t   dv_reg [QW];
    logic [QW-1:0]     p2_mag_x_reg, p2_mag_y_reg;
    logic [QW-1:0]     quo_x, quo_y;

    // Star table and its valid bits
    sfsu_pkg::star_t   mem [NS];
    logic [NS-1:0]     mem_vld_reg;
    logic              accept;
    logic              wr_en;
    sfsu_pkg::star_t   wr_star;
    logic [IW-1:0]     wr_idx;

    // Interlock: hold off a star that is still in flight.
    always_comb
    begin
        busy = (rd_vld_reg && rd_item_reg.star_index == item.star_index)
            || (p1_vld_reg && p1_reg.idx == item.star_index)
            || (p2_vld_reg && p2_reg.idx == item.star_index);
        for (int s = 0; s < QW; s++)
        begin
            if (dv_vld_reg[s] && dv_reg[s].idx == item.star_index)
            begin
                busy = 1'b1;
            end
        end
    end

    assign accept = start && !busy;

    // Table read when an item is taken; an entry never written reads as zero.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_star_reg <= mem[item.star_index];
            rd_hit_reg  <= mem_vld_reg[item.star_index];
            rd_item_reg <= item;
        end
        if (wr_en)
        begin
            mem[wr_idx] <= wr_star;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            mem_vld_reg[wr_idx] <= 1'b1;
        end
    end

    // Spawn position in Q.8 from a Q0.16 fraction.
    function automatic logic signed [sfsu_pkg::POS_W-1:0] spawn_pos(logic [15:0] f);
        logic [sfsu_pkg::POS_W-1:0] prod;
        prod = sfsu_pkg::POS_W'(f) * sfsu_pkg::POS_W'(sfsu_pkg::SPAWN_MUL);
        return sfsu_pkg::SPAWN_BASE + $signed(prod);
    endfunction

    // Stage 1: move the star in depth, respawn from set A when it passes the viewer.
    sfsu_pkg::star_t  cur_star;
    sfsu_pkg::side_t  p1_next;
    logic signed [DW+1:0] new_depth;

    always_comb
    begin
        cur_star  = rd_hit_reg ? rd_star_reg : '0;
        new_depth = $signed({2'b00, cur_star.depth}) - $signed({{DW{1'b0}}, cur_star.speed});
        p1_next   = '0;
        p1_next.idx           = rd_item_reg.star_index;
        p1_next.spawn_x_b     = rd_item_reg.spawn_x_b;
        p1_next.spawn_y_b     = rd_item_reg.spawn_y_b;
        p1_next.spawn_speed_b = rd_item_reg.spawn_speed_b;
        if (new_depth <= 0)
        begin
            p1_next.star.x     = spawn_pos(rd_item_reg.spawn_x_a);
            p1_next.star.y     = spawn_pos(rd_item_reg.spawn_y_a);
            p1_next.star.depth = DW'(rd_item_reg.star_index) + 1'b1;
            p1_next.star.speed = 2'd2 + {1'b0, rd_item_reg.spawn_speed_a};
        end
        else
        begin
            p1_next.star       = cur_star;
            p1_next.star.depth = new_depth[DW-1:0];
        end
    end

    // Stage 2: numerators x + centre * 256 * depth, split into sign and magnitude / 256.
    logic        [NW-10:0] cd_x, cd_y;
    logic signed [NW-1:0]  num_x, num_y;
    logic        [NW-1:0]  abs_x, abs_y;
    sfsu_pkg::side_t       p2_next;

    always_comb
    begin
        cd_x  = (NW-9)'(center_x_reg) * (NW-9)'(p1_reg.star.depth);
        cd_y  = (NW-9)'(center_y_reg) * (NW-9)'(p1_reg.star.depth);
        num_x = NW'(p1_reg.star.x) + $signed({1'b0, cd_x, 8'd0});
        num_y = NW'(p1_reg.star.y) + $signed({1'b0, cd_y, 8'd0});
        abs_x = num_x[NW-1] ? NW'(-num_x) : num_x;
        abs_y = num_y[NW-1] ? NW'(-num_y) : num_y;
        p2_next       = p1_reg;
        p2_next.neg_x = num_x[NW-1];
        p2_next.neg_y = num_y[NW-1];
    end

    always_ff @(posedge clk)
    begin
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        p2_mag_x_reg <= abs_x[QW+7:8];
        p2_mag_y_reg <= abs_y[QW+7:8];
        dv_reg[0]    <= p2_reg;
        for (int s = 1; s < QW; s++)
        begin
            dv_reg[s] <= dv_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            for (int s = 0; s < QW; s++)
            begin
                dv_vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            rd_vld_reg    <= accept;
            p1_vld_reg    <= rd_vld_reg;
            p2_vld_reg    <= p1_vld_reg;
            dv_vld_reg[0] <= p2_vld_reg;
            for (int s = 1; s < QW; s++)
            begin
                dv_vld_reg[s] <= dv_vld_reg[s-1];
            end
        end
    end

    // Truncating division by depth for both coordinates.
    sfsu_div u_div_x (
        .clk      (clk),
        .dividend (p2_mag_x_reg),
        .divisor  (p2_reg.star.depth),
        .quotient (quo_x)
    );

    sfsu_div u_div_y (
        .clk      (clk),
        .dividend (p2_mag_y_reg),
        .divisor  (p2_reg.star.depth),
        .quotient (quo_y)
    );

    // Remainder of a small value by a constant. rcp is floor(1024 / c), so the
    // quotient estimate is exact or one short and a single correction finishes it.
    function automatic logic [4:0] mod_small(logic [7:0] k, logic [4:0] c, logic [7:0] rcp);
        logic [15:0] prod;
        logic [5:0]  q;
        logic [7:0]  qc;
        logic [7:0]  r;
        prod = 16'(k) * 16'(rcp);
        q    = prod[15:10];
        qc   = 8'(q) * 8'(c);
        r    = k - qc;
        if (r >= {3'd0, c})
        begin
            r = 8'(r - {3'd0, c});
        end
        return r[4:0];
    endfunction

    // Final stage: bounds check, result fields and table write back.
    sfsu_pkg::side_t fin;
    logic [10:0]     cols_eff, rows_eff;
    logic            on_x, on_y, vis;
    logic [7:0]      k;
    sfsu_pkg::result_t res_next;

    always_comb
    begin
        fin      = dv_reg[QW-1];
        cols_eff = (cols_reg > 11'd1024) ? 11'd1024 : cols_reg;
        rows_eff = (rows_reg > 11'd1024) ? 11'd1024 : rows_reg;
        on_x     = (!fin.neg_x || quo_x == '0) && (quo_x < QW'(cols_eff));
        on_y     = (!fin.neg_y || quo_y == '0) && (quo_y < QW'(rows_eff));
        vis      = on_x && on_y;
        k        = 8'(fin.idx) + 8'd1;

        res_next = '0;
        if (vis)
        begin
            res_next.visible    = 1'b1;
            res_next.column     = quo_x[9:0];
            res_next.screen_row = quo_y[9:0];
            res_next.word_index = fin.idx[1:0];
            if (text_mode_reg)
                res_next.glyph_class = sfsu_pkg::GLYPH_TEXT;
            else if (fin.star.depth > sfsu_pkg::FAR_DEPTH)
                res_next.glyph_class = sfsu_pkg::GLYPH_FAR;
            else if (fin.star.depth > sfsu_pkg::MID_DEPTH)
                res_next.glyph_class = sfsu_pkg::GLYPH_MID;
            else if (word_mode_reg)
                res_next.glyph_class = sfsu_pkg::GLYPH_WORD;
            else
                res_next.glyph_class = sfsu_pkg::GLYPH_NEAR;
            case (color_mode_reg)
                sfsu_pkg::COLOR_EIGHT: res_next.color_slot = mod_small(k, 5'd7, 8'd146) + 5'd1;
                sfsu_pkg::COLOR_SIXTN: res_next.color_slot = mod_small(k, 5'd15, 8'd68) + 5'd1;
                sfsu_pkg::COLOR_GREY:  res_next.color_slot = mod_small(k, 5'd22, 8'd46);
                default:               res_next.color_slot = '0;
            endcase
        end

        // An off-screen star respawns from set B.
        wr_en  = dv_vld_reg[QW-1];
        wr_idx = fin.idx;
        if (vis)
        begin
            wr_star = fin.star;
        end
        else
        begin
            wr_star.x     = spawn_pos(fin.spawn_x_b);
            wr_star.y     = spawn_pos(fin.spawn_y_b);
            wr_star.depth = DW'(fin.idx) + 1'b1;
            wr_star.speed = 2'd2 + {1'b0, fin.spawn_speed_b};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= dv_vld_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        result <= res_next;
    end

endmodule
`default_nettype wire

// ----- hdl/sfsu_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, one new division per clock.
// Depends on sfsu_pkg for the quotient and divisor widths.
`default_nettype none
module sfsu_div (
    input  wire logic                          clk,
    input  wire logic [sfsu_pkg::QUO_W-1:0]    dividend,
    input  wire logic [sfsu_pkg::DEPTH_W-1:0]  divisor,
    output logic      [sfsu_pkg::QUO_W-1:0]    quotient
);

    localparam int QW = sfsu_pkg::QUO_W;
    localparam int DW = sfsu_pkg::DEPTH_W;

    logic [QW-1:0] a_reg [QW];
    logic [DW-1:0] r_reg [QW];
    logic [DW-1:0] d_reg [QW];

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic logic [QW+DW-1:0] div_step(logic [QW-1:0] a, logic [DW-1:0] r,
                                                  logic [DW-1:0] d);
        logic [DW:0]   t;
        logic          ge;
        logic [DW-1:0] rn;
        t  = {r, a[QW-1]};
        ge = (t >= {1'b0, d});
        rn = ge ? DW'(t - {1'b0, d}) : t[DW-1:0];
        return {a[QW-2:0], ge, rn};
    endfunction

    // Stage registers: stage s holds the state after s+1 steps.
    always_ff @(posedge clk)
    begin
        {a_reg[0], r_reg[0]} <= div_step(dividend, '0, divisor);
        d_reg[0] <= divisor;
        for (int s = 1; s < QW; s++)
        begin
            {a_reg[s], r_reg[s]} <= div_step(a_reg[s-1], r_reg[s-1], d_reg[s-1]);
            d_reg[s] <= d_reg[s-1];
        end
    end

    assign quotient = a_reg[QW-1];

endmodule
`default_nettype wire
